// ----- sv/retransmit_timeout_table_assert.svh -----
// Assertion macros shared by the checker of the retransmission timer table.
`ifndef RETRANSMIT_TIMEOUT_TABLE_ASSERT_SVH
`define RETRANSMIT_TIMEOUT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the block clock outside reset.
`define RTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("retransmit table: same-cycle check failed");

// Next-cycle implication, sampled on the block clock outside reset.
`define RTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("retransmit table: next-cycle check failed");

`endif

// ----- sv/rtt_pkg.sv -----
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, codes and sizes of the retransmission timer table.
// ----------------------------------------------------------------------------
package rtt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_ACK    = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [2:0] ACT_PIN     = 3'd0;
    localparam logic [2:0] ACT_RESEND  = 3'd1;
    localparam logic [2:0] ACT_DROP    = 3'd2;
    localparam logic [2:0] ACT_RELEASE = 3'd3;
    localparam logic [2:0] ACT_FULL    = 3'd4;

    localparam logic REG_RESEND_INTERVAL = 1'b0;
    localparam logic REG_MAX_SENDS       = 1'b1;

    localparam logic [7:0] SENDS_SAT = 8'hFF;

    typedef struct packed {
        logic        is_add;
        logic        is_ack;
        logic        is_cancel;
        logic        is_tick;
        logic [31:0] packet_id;
        logic [31:0] user_id;
        logic [15:0] proto_num;
        logic [15:0] buffer_handle;
        logic [15:0] dest_handle;
        logic [15:0] data_len;
        logic [31:0] now_time;
    } t_cmd;

    typedef struct packed {
        logic [31:0] packet_id;
        logic [31:0] user;
        logic [15:0] proto;
        logic [15:0] buffer;
        logic [15:0] dest;
        logic [15:0] length;
        logic [31:0] deadline;
        logic [7:0]  sends;
    } t_entry;

    typedef struct packed {
        logic [15:0] resend_interval;
        logic [7:0]  max_sends;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] packet_id;
        logic [15:0] buffer;
        logic [15:0] dest;
        logic [15:0] length;
        logic [7:0]  sends;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ----- sv/rtt_fifo.sv -----
// ----------------------------------------------------------------------------
// rtt_fifo
// Short command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module rtt_fifo import rtt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_push_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_stat
);
    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
        end
    end
endmodule

// ----- sv/rtt_front.sv -----
// ----------------------------------------------------------------------------
// rtt_front
// Command intake: accepts a command and decodes its opcode for the queue.
// ----------------------------------------------------------------------------
module rtt_front import rtt_pkg::*; (
    input  logic        i_start,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_packet_id,
    input  logic [31:0] i_user_id,
    input  logic [15:0] i_proto_num,
    input  logic [15:0] i_buffer_handle,
    input  logic [15:0] i_dest_handle,
    input  logic [15:0] i_data_len,
    input  logic [31:0] i_now_time,
    input  t_qstat      i_qstat,
    output logic        o_busy,
    output logic        o_push,
    output t_cmd        o_cmd
);
    assign o_busy = i_qstat.full;
    assign o_push = i_start && !i_qstat.full;

    always_comb begin
        o_cmd               = '0;
        o_cmd.packet_id     = i_packet_id;
        o_cmd.user_id       = i_user_id;
        o_cmd.proto_num     = i_proto_num;
        o_cmd.buffer_handle = i_buffer_handle;
        o_cmd.dest_handle   = i_dest_handle;
        o_cmd.data_len      = i_data_len;
        o_cmd.now_time      = i_now_time;
        unique case (i_opcode)
            OP_ADD:    o_cmd.is_add    = 1'b1;
            OP_ACK:    o_cmd.is_ack    = 1'b1;
            OP_CANCEL: o_cmd.is_cancel = 1'b1;
            default:   o_cmd.is_tick   = 1'b1;
        endcase
    end
endmodule

// ----- sv/rtt_engine.sv -----
// ----------------------------------------------------------------------------
// rtt_engine
// Table engine: walks the entry memory one entry per cycle for each command.
// ----------------------------------------------------------------------------
module rtt_engine import rtt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_qstat      i_qstat,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_strobe,
    output t_result     o_res,
    output logic        o_last
);
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    t_entry             r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [1:0]         r_state, n_state;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]   r_rd_idx;
    logic               r_rd_v, n_rd_v;
    t_entry             r_rd;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_hold_v, n_hold_v;
    t_result            r_hold, n_hold;
    logic               r_match_f, n_match_f, r_free_f, n_free_f;
    logic [IDX_W-1:0]   r_match, n_match, r_free, n_free;
    logic               r_strobe, n_strobe;
    t_result            r_res, n_res;
    logic               r_last, n_last;

    logic               w_en;
    logic [IDX_W-1:0]   w_addr;
    t_entry             w_data;
    logic               vld, room, due, new_v;
    logic [7:0]         sends_new;
    logic [31:0]        next_deadline;
    t_result            new_res;

    assign o_strobe = r_strobe;
    assign o_res    = r_res;
    assign o_last   = r_last;
    assign o_pop    = (r_state == ST_IDLE) && !i_qstat.empty;

    assign vld           = r_valid[r_rd_idx];
    assign room          = r_n < CNT_W'(MAX_RESULTS);
    assign next_deadline = r_cmd.now_time + 32'(i_cfg.resend_interval);
    assign sends_new     = (r_rd.sends == SENDS_SAT) ? SENDS_SAT : r_rd.sends + 8'd1;
    assign due           = vld && !(r_cmd.now_time < r_rd.deadline);

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_rd_v    = 1'b0;
        n_valid   = r_valid;
        n_n       = r_n;
        n_hold_v  = r_hold_v;
        n_hold    = r_hold;
        n_match_f = r_match_f;
        n_match   = r_match;
        n_free_f  = r_free_f;
        n_free    = r_free;
        n_strobe  = 1'b0;
        n_res     = r_res;
        n_last    = r_last;
        w_en      = 1'b0;
        w_addr    = r_rd_idx;
        w_data    = r_rd;
        new_v     = 1'b0;
        new_res   = '{action: ACT_RELEASE, packet_id: r_rd.packet_id, buffer: r_rd.buffer,
                      dest: r_rd.dest, length: r_rd.length, sends: r_rd.sends};

        // Per-entry work on the entry read in the previous cycle.
        if (r_rd_v) begin
            if (r_cmd.is_add) begin
                if (vld && r_rd.packet_id == r_cmd.packet_id && !r_match_f) begin
                    n_match_f = 1'b1;
                    n_match   = r_rd_idx;
                end
                if (!vld && !r_free_f) begin
                    n_free_f = 1'b1;
                    n_free   = r_rd_idx;
                end
            end else if (r_cmd.is_ack) begin
                if (vld && room && r_rd.packet_id == r_cmd.packet_id) begin
                    new_v             = 1'b1;
                    n_valid[r_rd_idx] = 1'b0;
                end
            end else if (r_cmd.is_cancel) begin
                if (vld && room && r_rd.user == r_cmd.user_id
                        && r_rd.proto == r_cmd.proto_num) begin
                    new_v             = 1'b1;
                    n_valid[r_rd_idx] = 1'b0;
                end
            end else if (due && room) begin
                w_en            = 1'b1;
                w_data.sends    = sends_new;
                w_data.deadline = next_deadline;
                new_v           = 1'b1;
                new_res.sends   = sends_new;
                if (sends_new < i_cfg.max_sends) begin
                    new_res.action = ACT_RESEND;
                end else begin
                    new_res.action    = ACT_DROP;
                    n_valid[r_rd_idx] = 1'b0;
                end
            end
        end

        // A held result goes out once the next one shows it was not the last.
        if (new_v) begin
            n_n = r_n + 1'b1;
            if (r_hold_v) begin
                n_strobe = 1'b1;
                n_res    = r_hold;
                n_last   = 1'b0;
            end
            n_hold_v = 1'b1;
            n_hold   = new_res;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    n_state   = ST_WALK;
                    n_addr    = '0;
                    n_n       = '0;
                    n_hold_v  = 1'b0;
                    n_match_f = 1'b0;
                    n_free_f  = 1'b0;
                end
            end
            ST_WALK: begin
                n_rd_v = 1'b1;
                if (r_addr == IDX_W'(TABLE_DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            default: begin
                n_state = ST_IDLE;
                if (r_cmd.is_add) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_res    = '{action: ACT_PIN, packet_id: r_cmd.packet_id,
                                 buffer: r_cmd.buffer_handle, dest: r_cmd.dest_handle,
                                 length: r_cmd.data_len, sends: 8'd0};
                    if (r_match_f || r_free_f) begin
                        w_en            = 1'b1;
                        w_addr          = r_match_f ? r_match : r_free;
                        w_data          = '{packet_id: r_cmd.packet_id, user: r_cmd.user_id,
                                            proto: r_cmd.proto_num,
                                            buffer: r_cmd.buffer_handle,
                                            dest: r_cmd.dest_handle, length: r_cmd.data_len,
                                            deadline: next_deadline, sends: 8'd0};
                        n_valid[w_addr] = 1'b1;
                    end else begin
                        n_res.action = ACT_FULL;
                    end
                end else if (r_hold_v) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_res    = r_hold;
                    n_hold_v = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd     <= r_mem[r_addr];
        r_rd_idx <= r_addr;
        if (o_pop) begin
            r_cmd <= i_head;
        end
        r_addr  <= n_addr;
        r_n     <= n_n;
        r_hold  <= n_hold;
        r_match <= n_match;
        r_free  <= n_free;
        r_res   <= n_res;
        r_last  <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_rd_v    <= 1'b0;
            r_hold_v  <= 1'b0;
            r_match_f <= 1'b0;
            r_free_f  <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_rd_v    <= n_rd_v;
            r_hold_v  <= n_hold_v;
            r_match_f <= n_match_f;
            r_free_f  <= n_free_f;
            r_strobe  <= n_strobe;
        end
    end
endmodule

// ----- sv/retransmit_timeout_table.sv -----
// ----------------------------------------------------------------------------
// retransmit_timeout_table
// Table of unacknowledged packets with resend deadlines, add/ack/cancel/tick.
// ----------------------------------------------------------------------------
// Usage: a command is transferred at a rising edge where start is high and
// busy is low. Commands wait in a four-deep queue, so busy rises only when
// that queue is full. Each command is carried out by a walk over all table
// entries, one entry per cycle through the entry memory read port; the next
// command leaves the queue only when the engine is idle again after that walk.
// Results appear one per cycle at most, each for exactly one cycle with
// o_strobe high; o_last marks the final result of a command. Add always
// gives one result (pin or table full); ack, cancel and tick give zero or
// more. The receiver cannot stall, so results are never held back.
// The configuration channel always accepts; write it only while idle.
// Reset empties the table and the queue and restores the register defaults
// (resend interval 1000, max sends 3); no clearing pass is needed.
module retransmit_timeout_table import rtt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_packet_id,
    input  logic [31:0] i_user_id,
    input  logic [15:0] i_proto_num,
    input  logic [15:0] i_buffer_handle,
    input  logic [15:0] i_dest_handle,
    input  logic [15:0] i_data_len,
    input  logic [31:0] i_now_time,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_action,
    output logic [31:0] o_packet_id_out,
    output logic [15:0] o_buffer_out,
    output logic [15:0] o_dest_out,
    output logic [15:0] o_len_out,
    output logic [7:0]  o_sends_out,
    output logic        o_last
);
    t_cfg    r_cfg;
    t_qstat  qstat;
    t_cmd    push_cmd, head;
    logic    push, pop;
    t_result res;

    // Configuration registers are written in place; the channel never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.resend_interval <= 16'd1000;
            r_cfg.max_sends       <= 8'd3;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RESEND_INTERVAL: r_cfg.resend_interval <= i_cfg_data;
                default:             r_cfg.max_sends       <= i_cfg_data[7:0];
            endcase
        end
    end

    rtt_front u_front (
        .i_start         (start),
        .i_opcode        (i_opcode),
        .i_packet_id     (i_packet_id),
        .i_user_id       (i_user_id),
        .i_proto_num     (i_proto_num),
        .i_buffer_handle (i_buffer_handle),
        .i_dest_handle   (i_dest_handle),
        .i_data_len      (i_data_len),
        .i_now_time      (i_now_time),
        .i_qstat         (qstat),
        .o_busy          (busy),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    rtt_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (qstat)
    );

    rtt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_qstat  (qstat),
        .i_head   (head),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_res    (res),
        .o_last   (o_last)
    );

    assign o_action        = res.action;
    assign o_packet_id_out = res.packet_id;
    assign o_buffer_out    = res.buffer;
    assign o_dest_out      = res.dest;
    assign o_len_out       = res.length;
    assign o_sends_out     = res.sends;
endmodule

// ----- sv/rtt_checker.sv -----
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the retransmission timer table, bound to the top level.
// ----------------------------------------------------------------------------
`include "retransmit_timeout_table_assert.svh"

module rtt_checker import rtt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_cfg_ready,
    input logic        o_strobe,
    input logic [2:0]  o_action,
    input logic [7:0]  o_sends_out,
    input logic        o_last
);
    // Pin and table-full results are always the only result of an add.
    `RTT_ASSERT_NOW(a_add_single, o_strobe && (o_action == ACT_PIN || o_action == ACT_FULL), o_last)
    // Results made from the input of an add carry no send count.
    `RTT_ASSERT_NOW(a_add_sends, o_strobe && (o_action == ACT_PIN || o_action == ACT_FULL), o_sends_out == 8'd0)
    // Action codes stay within the defined set.
    `RTT_ASSERT_NOW(a_action_range, o_strobe, o_action <= ACT_FULL)
    // A resend or drop always follows at least one send.
    `RTT_ASSERT_NOW(a_tick_sends, o_strobe && (o_action == ACT_RESEND || o_action == ACT_DROP), o_sends_out != 8'd0)
    // The configuration channel never stalls a write.
    `RTT_ASSERT_NEXT(a_cfg_ready, start || busy || !start, o_cfg_ready)
endmodule

bind retransmit_timeout_table rtt_checker u_rtt_checker (.*);
